// ===== rtl/core/lbp_pkg.sv =====
package lbp_pkg;

    localparam int LINE_MAX  = 1024;
    localparam int LINES_MAX = 4096;

    localparam int PIX_W = 8;
    localparam int COL_W = $clog2(LINE_MAX);
    localparam int ROW_W = $clog2(LINES_MAX);
    localparam int LEN_W = $clog2(LINE_MAX + 1);
    localparam int CNT_W = $clog2(LINES_MAX + 1);

    // Raw widths of the configuration registers as software writes them.
    localparam int MODE_RAW_W = 2;
    localparam int LEN_RAW_W  = 11;
    localparam int CNT_RAW_W  = 13;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;

    localparam int OUT_DEPTH = 3;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OUTPUT_MODE = 2'd0,
        CFG_LINE_LENGTH = 2'd1,
        CFG_LINE_COUNT  = 2'd2
    } cfg_index_t;

    typedef enum logic [MODE_RAW_W-1:0] {
        MODE_RAW     = 2'd0,
        MODE_ROT_MIN = 2'd1,
        MODE_UNIFORM = 2'd2
    } mode_t;

    // Position flags that travel with a pixel into the window stage.
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic             emit;
        logic             last;
    } slot_t;

    // Line store write-back issued by the window stage.
    typedef struct packed {
        logic             en;
        logic [COL_W-1:0] addr;
        logic [PIX_W-1:0] older;
        logic [PIX_W-1:0] newer;
    } wr_t;

    typedef struct packed {
        logic [PIX_W-1:0] code;
        logic             last;
    } result_t;

    typedef logic [PIX_W-1:0] label_table_t [256];

    // Uniform labels: codes with at most two circular transitions are
    // numbered from one in ascending code order, all others map to zero.
    function automatic label_table_t build_uniform_table();
        label_table_t tbl;
        int           next;
        logic [7:0]   c;
        next = 1;
        for (int i = 0; i < 256; i++) begin
            c = i[7:0];
            if ($countones(c ^ {c[0], c[7:1]}) < 3) begin
                tbl[i] = next[PIX_W-1:0];
                next   = next + 1;
            end
            else begin
                tbl[i] = '0;
            end
        end
        return tbl;
    endfunction

    localparam label_table_t UNIFORM_LABEL = build_uniform_table();

    // Smallest of the eight bit rotations of a code.
    function automatic logic [7:0] rotation_min(input logic [7:0] c);
        logic [7:0] best;
        logic [7:0] rot;
        best = c;
        for (int i = 1; i < 8; i++) begin
            rot = (c << i) | (c >> (8 - i));
            if (rot < best) begin
                best = rot;
            end
        end
        return best;
    endfunction

endpackage

// ===== rtl/core/lbp_ram.sv =====
module lbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/core/lbp_window.sv =====
module lbp_window
    import lbp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  logic [PIX_W-1:0]      pixel,
    input  slot_t                 slot,
    input  logic [MODE_RAW_W-1:0] mode,
    input  logic [PIX_W-1:0]      top_data,
    input  logic [PIX_W-1:0]      mid_data,
    output logic                  busy,
    output wr_t                   wr,
    output logic                  push,
    output result_t               result
);

    logic             s1_valid_reg;
    logic [PIX_W-1:0] s1_pixel_reg;
    slot_t            s1_slot_reg;
    logic [PIX_W-1:0] win_reg [6];

    logic [PIX_W-1:0] center;
    logic [7:0]       raw_code;
    logic [7:0]       mapped_code;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pixel_reg <= pixel;
            s1_slot_reg  <= slot;
        end
    end

    // Columns x-2 and x-1 of the three window rows.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (s1_valid_reg)
        begin
            win_reg[0] <= win_reg[1];
            win_reg[1] <= top_data;
            win_reg[2] <= win_reg[3];
            win_reg[3] <= mid_data;
            win_reg[4] <= win_reg[5];
            win_reg[5] <= s1_pixel_reg;
        end
    end

    always_comb
    begin
        center      = win_reg[3];
        raw_code[7] = win_reg[0] > center;
        raw_code[6] = win_reg[1] > center;
        raw_code[5] = top_data > center;
        raw_code[4] = mid_data > center;
        raw_code[3] = s1_pixel_reg > center;
        raw_code[2] = win_reg[5] > center;
        raw_code[1] = win_reg[4] > center;
        raw_code[0] = win_reg[2] > center;
        case (mode)
            MODE_ROT_MIN: mapped_code = rotation_min(raw_code);
            MODE_UNIFORM: mapped_code = UNIFORM_LABEL[raw_code];
            default:      mapped_code = raw_code;
        endcase
    end

    assign busy        = s1_valid_reg;
    assign wr.en       = s1_valid_reg;
    assign wr.addr     = s1_slot_reg.col;
    assign wr.older    = mid_data;
    assign wr.newer    = s1_pixel_reg;
    assign push        = s1_valid_reg && s1_slot_reg.emit;
    assign result.code = mapped_code;
    assign result.last = s1_slot_reg.last;

endmodule

// ===== rtl/core/lbp_out_fifo.sv =====
module lbp_out_fifo
    import lbp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  result_t              push_data,
    input  logic                 pop,
    output logic                 valid,
    output result_t              head,
    output logic [OUT_CNT_W-1:0] count
);

    result_t               slot_reg [OUT_DEPTH];
    logic [OUT_PTR_W-1:0]  wr_ptr_reg;
    logic [OUT_PTR_W-1:0]  rd_ptr_reg;
    logic [OUT_CNT_W-1:0]  count_reg;
    logic                  do_pop;

    assign valid  = count_reg != '0;
    assign do_pop = pop && valid;
    assign head   = slot_reg[rd_ptr_reg];
    assign count  = count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0
                                                                        : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0
                                                                        : rd_ptr_reg + 1'b1;
            end
            if (push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/core/lbp_3x3_code_stream_core.sv =====
// 3x3 local binary pattern over a raster pixel stream. Pixels enter one per
// item on the slave stream; for every interior pixel one 8-bit code leaves on
// the master stream, in interior raster order, with tlast set on the final
// code of the frame. Border pixels give no output item. Bit 7 of a raw code is
// the upper-left neighbor and the bits run clockwise to the left neighbor in
// bit 0; a bit is set when that neighbor is strictly greater than the center.
// output_mode selects the raw code, the minimum over its eight rotations, or
// its uniform label (1..58 for patterns with at most two circular transitions,
// 0 otherwise); mode 3 gives the raw code. The block takes one pixel per clock
// cycle while the output queue has room: the two line stores are read in the
// cycle an item is accepted and written back in the next cycle at a different
// column, so the single read port and single write port of each store carry
// one pixel per cycle. A code passes the window stage register into a
// three-entry output queue, which lets input keep flowing while a finished
// code waits. Writing line_length or line_count clamps the value to its legal
// range and restarts the frame at its first pixel; configuration must be
// written only while the block is idle (the block does not enforce this),
// and output_mode applies from the next code on. The line stores need no
// clearing after reset, since any entry read for a code is written first.
module lbp_3x3_code_stream_core
    import lbp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Pixel input stream.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // [7:0] pixel
    // Code output stream.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [7:0]            m_axis_tdata,   // [7:0] code
    output logic                  m_axis_tlast,   // last_of_frame
    // Configuration write channel.
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [MODE_RAW_W-1:0] mode_reg;
    logic [LEN_W-1:0]      len_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [COL_W-1:0]      col_reg;
    logic [ROW_W-1:0]      row_reg;

    logic                  in_accept;
    logic                  cfg_accept;
    logic                  col_wrap;
    logic                  row_wrap;
    slot_t                 slot;
    logic [LEN_RAW_W-1:0]  len_raw;
    logic [CNT_RAW_W-1:0]  cnt_raw;
    logic [LEN_W-1:0]      len_clamped;
    logic [CNT_W-1:0]      cnt_clamped;

    logic [PIX_W-1:0]      top_data;
    logic [PIX_W-1:0]      mid_data;
    logic                  win_busy;
    wr_t                   wr;
    logic                  push;
    result_t               result;
    result_t               head;
    logic [OUT_CNT_W-1:0]  out_count;
    logic [OUT_CNT_W:0]    out_claim;

    // An accepted pixel may still produce a code in the next cycle, so the
    // queue must hold room for it as well as for everything already inside.
    assign out_claim     = {1'b0, out_count} + (OUT_CNT_W + 1)'(win_busy);
    assign s_axis_tready = out_claim < (OUT_CNT_W + 1)'(OUT_DEPTH);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;
    assign cfg_accept    = cfg_valid && cfg_ready;

    // Clamp the written sizes to the legal range.
    always_comb
    begin
        len_raw = cfg_data[LEN_RAW_W-1:0];
        cnt_raw = cfg_data[CNT_RAW_W-1:0];
        if (len_raw < LEN_RAW_W'(3))
        begin
            len_clamped = LEN_W'(3);
        end
        else if (len_raw > LEN_RAW_W'(LINE_MAX))
        begin
            len_clamped = LEN_W'(LINE_MAX);
        end
        else
        begin
            len_clamped = LEN_W'(len_raw);
        end
        if (cnt_raw < CNT_RAW_W'(3))
        begin
            cnt_clamped = CNT_W'(3);
        end
        else if (cnt_raw > CNT_RAW_W'(LINES_MAX))
        begin
            cnt_clamped = CNT_W'(LINES_MAX);
        end
        else
        begin
            cnt_clamped = CNT_W'(cnt_raw);
        end
    end

    // The column and row counters always stay below the active sizes, so an
    // equality test is enough to find the end of a line or frame.
    assign col_wrap  = ({1'b0, col_reg} + 1'b1) == len_reg;
    assign row_wrap  = ({1'b0, row_reg} + 1'b1) == cnt_reg;
    assign slot.col  = col_reg;
    assign slot.emit = (col_reg >= COL_W'(2)) && (row_reg >= ROW_W'(2));
    assign slot.last = col_wrap && row_wrap;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_RAW;
            len_reg  <= LEN_W'(LINE_MAX);
            cnt_reg  <= CNT_W'(LINE_MAX);
            col_reg  <= '0;
            row_reg  <= '0;
        end
        else if (cfg_accept)
        begin
            case (cfg_index)
                CFG_OUTPUT_MODE:
                begin
                    mode_reg <= cfg_data[MODE_RAW_W-1:0];
                end
                CFG_LINE_LENGTH:
                begin
                    len_reg <= len_clamped;
                    col_reg <= '0;
                    row_reg <= '0;
                end
                CFG_LINE_COUNT:
                begin
                    cnt_reg <= cnt_clamped;
                    col_reg <= '0;
                    row_reg <= '0;
                end
                default:
                begin
                    mode_reg <= mode_reg;
                end
            endcase
        end
        else if (in_accept)
        begin
            if (col_wrap)
            begin
                col_reg <= '0;
                row_reg <= row_wrap ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_reg <= col_reg + 1'b1;
            end
        end
    end

    // Older line store: the line two above the incoming pixel.
    lbp_ram #(
        .WIDTH (PIX_W),
        .DEPTH (LINE_MAX)
    ) u_older_ram (
        .clk     (clk),
        .wr_en   (wr.en),
        .wr_addr (wr.addr),
        .wr_data (wr.older),
        .rd_en   (in_accept),
        .rd_addr (col_reg),
        .rd_data (top_data)
    );

    // Newer line store: the line directly above the incoming pixel.
    lbp_ram #(
        .WIDTH (PIX_W),
        .DEPTH (LINE_MAX)
    ) u_newer_ram (
        .clk     (clk),
        .wr_en   (wr.en),
        .wr_addr (wr.addr),
        .wr_data (wr.newer),
        .rd_en   (in_accept),
        .rd_addr (col_reg),
        .rd_data (mid_data)
    );

    lbp_window u_window (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (in_accept),
        .pixel    (s_axis_tdata),
        .slot     (slot),
        .mode     (mode_reg),
        .top_data (top_data),
        .mid_data (mid_data),
        .busy     (win_busy),
        .wr       (wr),
        .push     (push),
        .result   (result)
    );

    lbp_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (result),
        .pop       (m_axis_tready),
        .valid     (m_axis_tvalid),
        .head      (head),
        .count     (out_count)
    );

    assign m_axis_tdata = head.code;
    assign m_axis_tlast = head.last;

endmodule

// ===== rtl/core/lbp_checker.sv =====
module lbp_checker
    import lbp_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [7:0]            m_axis_tdata,
    input logic                  m_axis_tlast
);

    logic s_accept;

    assign s_accept = s_axis_tvalid && s_axis_tready;

    // A code waiting on the output keeps its value until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output item changed while stalled");

    // A fresh code appears after the pixel that caused it has passed the window stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_accept, 2))
    else $error("output item without a matching input two cycles earlier");

    // With nothing queued and nothing in flight, input must be taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid && !$past(s_accept) && !$past(s_accept, 2) |-> s_axis_tready)
    else $error("input stalled while the block is empty");

endmodule

bind lbp_3x3_code_stream_core lbp_checker u_lbp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

// ===== tb/lbp_code_checker.sv =====
`timescale 1ns / 1ps

// Watches the pixel, code and configuration channels of the LBP core, keeps
// its own copy of the line stores and the 3x3 window, and compares every code
// that leaves the core with the oldest code it has worked out.
module lbp_code_checker
    import lbp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [7:0]            m_axis_tdata,
    input  logic                  m_axis_tlast,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatches,
    output int                    pending
);

    logic [7:0] older_line [LINE_MAX];
    logic [7:0] newer_line [LINE_MAX];
    // 0,1 top row x-2,x-1; 2,3 middle row; 4,5 bottom row.
    logic [7:0] window [6];
    logic [7:0] label_of [256];
    int         col;
    int         row;
    logic [1:0] mode;
    int         len_raw;
    int         cnt_raw;
    result_t    expected_codes [$];
    result_t    oldest;

    initial
    begin
        int         flips;
        int         next_label;
        logic [7:0] v;
        next_label = 1;
        for (int c = 0; c < 256; c++)
        begin
            v     = c[7:0];
            flips = 0;
            for (int i = 0; i < 8; i++)
            begin
                if (v[i] != v[(i + 1) % 8])
                begin
                    flips++;
                end
            end
            if (flips <= 2)
            begin
                label_of[c] = next_label[7:0];
                next_label++;
            end
            else
            begin
                label_of[c] = 8'd0;
            end
        end
    end

    function automatic int clamp_to(input int v, input int lo, input int hi);
        if (v < lo)
        begin
            return lo;
        end
        if (v > hi)
        begin
            return hi;
        end
        return v;
    endfunction

    function automatic logic [7:0] smallest_rotation(input logic [7:0] c);
        logic [7:0] r;
        logic [7:0] best;
        r    = c;
        best = c;
        for (int i = 1; i < 8; i++)
        begin
            r = {r[6:0], r[7]};
            if (r < best)
            begin
                best = r;
            end
        end
        return best;
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] wanted,
                                   input logic [7:0] got);
        $display("%0t ns: %s: expected %0d, observed %0d", $time, what, wanted, got);
        mismatches++;
    endtask

    // One pixel enters the window; an interior center yields one code.
    task automatic advance_window(input logic [7:0] pix);
        int         eff_len;
        int         eff_cnt;
        logic [7:0] top_px;
        logic [7:0] mid_px;
        logic [7:0] ctr;
        logic [7:0] raw;
        result_t    item;
        eff_len = clamp_to(len_raw, 3, LINE_MAX);
        eff_cnt = clamp_to(cnt_raw, 3, LINES_MAX);
        top_px  = older_line[col];
        mid_px  = newer_line[col];
        if (col >= 2 && row >= 2 && col < eff_len && row < eff_cnt)
        begin
            ctr = window[3];
            raw = {window[0] > ctr, window[1] > ctr, top_px > ctr, mid_px > ctr,
                   pix > ctr, window[5] > ctr, window[4] > ctr, window[2] > ctr};
            if (mode == MODE_ROT_MIN)
            begin
                item.code = smallest_rotation(raw);
            end
            else if (mode == MODE_UNIFORM)
            begin
                item.code = label_of[raw];
            end
            else
            begin
                item.code = raw;
            end
            item.last = (col == eff_len - 1) && (row == eff_cnt - 1);
            expected_codes.push_back(item);
        end
        older_line[col] = mid_px;
        newer_line[col] = pix;
        window[0] = window[1];
        window[1] = top_px;
        window[2] = window[3];
        window[3] = mid_px;
        window[4] = window[5];
        window[5] = pix;
        col++;
        if (col >= eff_len)
        begin
            col = 0;
            row++;
            if (row >= eff_cnt)
            begin
                row = 0;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                window[i] = 8'd0;
            end
            col        = 0;
            row        = 0;
            mode       = MODE_RAW;
            len_raw    = 1024;
            cnt_raw    = 1024;
            expected_codes.delete();
            pending    = 0;
            mismatches = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_codes.size() == 0)
                begin
                    report_mismatch("code with none expected", 8'd0, m_axis_tdata);
                end
                else
                begin
                    oldest = expected_codes.pop_front();
                    if (m_axis_tdata !== oldest.code)
                    begin
                        report_mismatch("code", oldest.code, m_axis_tdata);
                    end
                    if (m_axis_tlast !== oldest.last)
                    begin
                        report_mismatch("tlast", {7'd0, oldest.last}, {7'd0, m_axis_tlast});
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_OUTPUT_MODE:
                    begin
                        mode = cfg_data[1:0];
                    end
                    CFG_LINE_LENGTH:
                    begin
                        len_raw = int'(cfg_data[10:0]);
                        col     = 0;
                        row     = 0;
                    end
                    CFG_LINE_COUNT:
                    begin
                        cnt_raw = int'(cfg_data[12:0]);
                        col     = 0;
                        row     = 0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                advance_window(s_axis_tdata);
            end
            pending = expected_codes.size();
        end
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

// Top of the LBP core testbench. This module only makes stimulus and gives the
// verdict: a pixel sender on the slave stream, a code receiver on the master
// stream, and a writer for the configuration channel. All prediction and
// comparison happens in the checker instantiated next to the core.
module tb_top;
    import lbp_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int CYCLE_LIMIT  = 400000;
    // Cycles to let in-flight pixels settle before touching configuration.
    localparam int SETTLE_CYCLES = 16;
    // An index past the register list; the core must ignore writes to it.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_INDEX = 2'd3;

    // Who idles: the receiver heavily, the sender heavily, or nobody.
    typedef enum int {IDLE_RX_HEAVY, IDLE_TX_HEAVY, IDLE_NONE} idle_scheme_t;
    // How the pixels of a frame are drawn.
    typedef enum int {PIX_ANY, PIX_TIES, PIX_EXTREME, PIX_NARROW} pixel_style_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [7:0]            m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int mismatches;
    int pending;
    int cycle_count = 0;
    int tx_idle_pct;
    int rx_idle_pct;
    // Effective frame size, kept so that phases can send whole frames.
    int cur_len;
    int cur_cnt;

    logic [7:0] corner_frame [15];
    logic [7:0] tie_frame [9];

    lbp_3x3_code_stream_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    lbp_code_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .pending       (pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Watchdog. The limit is many times the slowest legal run, so hitting it
    // means the core has stopped moving items.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // The receiver stalls at random; the rate follows the current idle scheme.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    function automatic int clamp_dim(input int v, input int lo, input int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic logic [7:0] draw_pixel(input pixel_style_t style);
        case (style)
            PIX_TIES:    return 8'($urandom_range(0, 3));
            PIX_EXTREME: return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
            PIX_NARROW:  return 8'(120 + $urandom_range(0, 15));
            default:     return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic pixel_style_t draw_style();
        case ($urandom_range(0, 3))
            0:       return PIX_TIES;
            1:       return PIX_EXTREME;
            2:       return PIX_NARROW;
            default: return PIX_ANY;
        endcase
    endfunction

    // Called at a falling edge. The sender may hold back for a random number
    // of cycles, then offers the item until the core takes it, and returns at
    // the next falling edge with tvalid still high.
    task automatic send_pixel(input logic [7:0] pix);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pix;
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // Stop sending, wait for every expected code, then give pixels that make
    // no code time to leave the pipeline so that the core is truly idle.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_idling(input idle_scheme_t scheme);
        case (scheme)
            IDLE_RX_HEAVY:
            begin
                tx_idle_pct = 15;
                rx_idle_pct = 57;
            end
            IDLE_TX_HEAVY:
            begin
                tx_idle_pct = 57;
                rx_idle_pct = 15;
            end
            default:
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
        endcase
    endtask

    // One configuration setting followed by whole frames of random pixels
    // and an optional partial frame. Without a restart only the output mode
    // is written, so the frame in progress carries on under the new mode.
    task automatic run_phase(input idle_scheme_t scheme, input logic [12:0] mode_w,
                             input bit restart, input logic [12:0] len_w,
                             input logic [12:0] cnt_w, input int frames,
                             input int tail);
        pixel_style_t style;
        settle();
        set_idling(scheme);
        write_reg(CFG_OUTPUT_MODE, mode_w);
        if (restart)
        begin
            write_reg(CFG_LINE_LENGTH, len_w);
            write_reg(CFG_LINE_COUNT, cnt_w);
            cur_len = clamp_dim(int'(len_w[10:0]), 3, LINE_MAX);
            cur_cnt = clamp_dim(int'(cnt_w), 3, LINES_MAX);
        end
        for (int f = 0; f < frames; f++)
        begin
            style = draw_style();
            for (int n = 0; n < cur_len * cur_cnt; n++)
            begin
                send_pixel(draw_pixel(style));
            end
        end
        for (int n = 0; n < tail; n++)
        begin
            send_pixel(draw_pixel(PIX_ANY));
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'd0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_OUTPUT_MODE;
        cfg_data      = '0;
        cur_len       = 1024;
        cur_cnt       = 1024;
        set_idling(IDLE_RX_HEAVY);

        // A 5x3 frame with three centers: one whose neighbors tie with it or
        // sit on both sides, one of value zero with every neighbor above it
        // (all bits set), and one of value 255 with none above it.
        corner_frame = '{8'd255, 8'd1,   8'd255, 8'd1,   8'd0,
                         8'd255, 8'd128, 8'd0,   8'd255, 8'd255,
                         8'd255, 8'd255, 8'd128, 8'd1,   8'd0};
        // A 3x3 frame for mode three, which has to behave as the raw mode.
        tie_frame = '{8'd101, 8'd99,  8'd100,
                      8'd255, 8'd100, 8'd200,
                      8'd101, 8'd100, 8'd0};

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part.
        run_phase(IDLE_RX_HEAVY, 13'(MODE_RAW), 1'b1, 13'd5, 13'd3, 0, 0);
        foreach (corner_frame[i])
        begin
            send_pixel(corner_frame[i]);
        end
        run_phase(IDLE_RX_HEAVY, 13'd3, 1'b1, 13'd3, 13'd3, 0, 0);
        foreach (tie_frame[i])
        begin
            send_pixel(tie_frame[i]);
        end

        // Random part. A zero length and a count of one clamp up to the smallest frame.
        run_phase(IDLE_RX_HEAVY, 13'(MODE_ROT_MIN), 1'b1, 13'd0, 13'd1, 8, 0);
        run_phase(IDLE_RX_HEAVY, 13'(MODE_UNIFORM), 1'b1, 13'd8, 13'd6, 4, 11);
        // Only the mode changes here, with a mid-frame position and high
        // data bits that the register must drop.
        run_phase(IDLE_RX_HEAVY, 13'h1FFC, 1'b0, 13'd0, 13'd0, 1, 0);
        // Bits above the line length field are dropped, leaving five.
        run_phase(IDLE_RX_HEAVY, 13'(MODE_ROT_MIN), 1'b1, 13'h1805, 13'd4, 8, 0);
        run_phase(IDLE_TX_HEAVY, 13'(MODE_UNIFORM), 1'b1, 13'd16, 13'd8, 1, 0);
        // Line count far past its maximum: a partial frame that never ends.
        run_phase(IDLE_TX_HEAVY, 13'd3, 1'b1, 13'd3, 13'h1FFF, 0, 60);
        // A write past the register list must change nothing.
        settle();
        write_reg(CFG_SPARE_INDEX, 13'h0AAA);
        for (int n = 0; n < 40; n++)
        begin
            send_pixel(draw_pixel(PIX_ANY));
        end
        // The widest line, reached by clamping an oversized length. Only the
        // start of its first line is sent, which must make no code.
        run_phase(IDLE_TX_HEAVY, 13'(MODE_ROT_MIN), 1'b1, 13'd2047, 13'd3, 0, 150);
        run_phase(IDLE_NONE, 13'(MODE_UNIFORM), 1'b1, 13'd32, 13'd10, 1, 0);
        run_phase(IDLE_NONE, 13'(MODE_UNIFORM), 1'b1, 13'd4, 13'd3, 15, 0);
        run_phase(IDLE_NONE, 13'(MODE_RAW), 1'b1, 13'd1024, 13'd4096, 0, 400);

        settle();
        if (mismatches == 0 && pending == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
